// ===== design/color_threshold_blob_centroid_core_macros.svh =====
`ifndef COLOR_THRESHOLD_BLOB_CENTROID_CORE_MACROS_SVH
`define COLOR_THRESHOLD_BLOB_CENTROID_CORE_MACROS_SVH

// Clocked assertion, held off while reset is low.
`define CTBC_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Assertion that a condition never occurs.
`define CTBC_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  `CTBC_ASSERT_CLK(lbl, clk, rstn, !(cond), msg)

`endif

// ===== design/ctbc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ctbc_pkg;

  localparam int unsigned COLS    = 160;
  localparam int unsigned ROWS    = 120;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned COL_W   = 8;
  localparam int unsigned ROW_W   = 7;
  localparam int unsigned SUM_W   = 23;
  localparam int unsigned CNT_W   = 15;
  localparam int unsigned CX_W    = 9;
  localparam int unsigned CY_W    = 8;
  localparam int unsigned CFG_W   = 15;
  localparam int unsigned IDX_W   = 2;

  localparam int unsigned Q_DEPTH = 4;
  localparam int unsigned Q_AW    = $clog2(Q_DEPTH);

  localparam logic [IDX_W-1:0] REG_V_MIN     = 2'd0;
  localparam logic [IDX_W-1:0] REG_V_MAX     = 2'd1;
  localparam logic [IDX_W-1:0] REG_MIN_COUNT = 2'd2;

  localparam logic [PIX_W-1:0] V_MIN_RST     = 8'd200;
  localparam logic [PIX_W-1:0] V_MAX_RST     = 8'd240;
  localparam logic [CNT_W-1:0] MIN_COUNT_RST = 15'd5;

  typedef struct packed {
    logic [PIX_W-1:0] v_min;
    logic [PIX_W-1:0] v_max;
    logic [CNT_W-1:0] min_count;
  } ctbc_cfg_t;

  // One classified sample on its way from front to back.
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             last;
    logic             found;
    logic [SUM_W-1:0] sum_x;
    logic [SUM_W-1:0] sum_y;
    logic [CNT_W-1:0] cnt;
  } ctbc_entry_t;

endpackage

`default_nettype wire

// ===== design/color_threshold_blob_centroid_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// V-plane colour-window blob centroid. Samples enter one per clock in raster
// order while full is low, and each gives one result item: the sample, or
// zero when it lies in v_min..v_max. The frame's last sample also carries the
// centroid (doubled column and row units) or the default centre (COLS, ROWS)
// when too few samples matched. When a blob is found, the back end runs a
// restoring divider, x and y in parallel, one quotient bit a cycle, for that
// item. A four-entry queue between the classifier and the divider absorbs
// part of that wait; the input can show full after a frame's last sample
// while the divider runs, and longer when the result side stalls.
module color_threshold_blob_centroid_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [ctbc_pkg::IDX_W-1:0]    cfg_idx_i,
  input  wire [ctbc_pkg::CFG_W-1:0]    cfg_wdata_i,
  input  wire                          push,
  output logic                         full,
  input  wire [ctbc_pkg::PIX_W-1:0]    v_sample_i,
  output logic                         empty,
  input  wire                          pop,
  output logic [ctbc_pkg::PIX_W-1:0]   out_pixel_o,
  output logic                         frame_done_o,
  output logic                         blob_found_o,
  output logic [ctbc_pkg::CX_W-1:0]    centre_x_o,
  output logic [ctbc_pkg::CY_W-1:0]    centre_y_o
);
  import ctbc_pkg::*;

  ctbc_cfg_t   cfg_q, cfg_d;
  ctbc_entry_t f_data, q_head;
  logic        f_push, q_full, q_empty, q_pop;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_V_MIN:     cfg_d.v_min     = cfg_wdata_i[PIX_W-1:0];
        REG_V_MAX:     cfg_d.v_max     = cfg_wdata_i[PIX_W-1:0];
        REG_MIN_COUNT: cfg_d.min_count = cfg_wdata_i[CNT_W-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.v_min     <= V_MIN_RST;
      cfg_q.v_max     <= V_MAX_RST;
      cfg_q.min_count <= MIN_COUNT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign full = q_full;

  ctbc_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push_i     (push),
    .v_sample_i (v_sample_i),
    .q_full_i   (q_full),
    .q_push_o   (f_push),
    .q_data_o   (f_data)
  );

  ctbc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (f_data),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_head)
  );

  ctbc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_data_i     (q_head),
    .q_pop_o      (q_pop),
    .empty_o      (empty),
    .pop_i        (pop),
    .out_pixel_o  (out_pixel_o),
    .frame_done_o (frame_done_o),
    .blob_found_o (blob_found_o),
    .centre_x_o   (centre_x_o),
    .centre_y_o   (centre_y_o)
  );

endmodule

`default_nettype wire

// ===== design/ctbc_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ctbc_front (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  ctbc_pkg::ctbc_cfg_t          cfg_i,
  input  wire                          push_i,
  input  wire [ctbc_pkg::PIX_W-1:0]    v_sample_i,
  input  wire                          q_full_i,
  output logic                         q_push_o,
  output ctbc_pkg::ctbc_entry_t        q_data_o
);
  import ctbc_pkg::*;

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic [SUM_W-1:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  logic hit, last_col, last;
  logic [SUM_W-1:0] sum_x_n, sum_y_n;
  logic [CNT_W-1:0] cnt_n;

  assign q_push_o = push_i && !q_full_i;

  always_comb begin
    hit      = (v_sample_i >= cfg_i.v_min) && (v_sample_i <= cfg_i.v_max);
    last_col = col_q >= COL_W'(COLS - 1);
    last     = last_col && (row_q >= ROW_W'(ROWS - 1));

    sum_x_n = sum_x_q;
    sum_y_n = sum_y_q;
    cnt_n   = cnt_q;
    if (hit) begin
      sum_x_n = sum_x_q + SUM_W'({col_q, 1'b0});
      sum_y_n = sum_y_q + SUM_W'({row_q, 1'b0});
      cnt_n   = cnt_q + CNT_W'(1);
    end

    q_data_o.pixel = hit ? '0 : v_sample_i;
    q_data_o.last  = last;
    q_data_o.found = last && (cnt_n > cfg_i.min_count) && (cnt_n != '0);
    q_data_o.sum_x = sum_x_n;
    q_data_o.sum_y = sum_y_n;
    q_data_o.cnt   = cnt_n;

    col_d   = col_q;
    row_d   = row_q;
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    cnt_d   = cnt_q;
    if (q_push_o) begin
      priority if (last) begin
        // clear for the next frame
        col_d   = '0;
        row_d   = '0;
        sum_x_d = '0;
        sum_y_d = '0;
        cnt_d   = '0;
      end else if (last_col) begin
        col_d   = '0;
        row_d   = row_q + ROW_W'(1);
        sum_x_d = sum_x_n;
        sum_y_d = sum_y_n;
        cnt_d   = cnt_n;
      end else begin
        col_d   = col_q + COL_W'(1);
        sum_x_d = sum_x_n;
        sum_y_d = sum_y_n;
        cnt_d   = cnt_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      sum_x_q <= '0;
      sum_y_q <= '0;
      cnt_q   <= '0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      sum_x_q <= sum_x_d;
      sum_y_q <= sum_y_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/ctbc_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "color_threshold_blob_centroid_core_macros.svh"

module ctbc_fifo (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  ctbc_pkg::ctbc_entry_t  data_i,
  output logic                   full_o,
  input  wire                    pop_i,
  output logic                   empty_o,
  output ctbc_pkg::ctbc_entry_t  data_o
);
  import ctbc_pkg::*;

  ctbc_entry_t     slot_q [Q_DEPTH];
  logic [Q_AW-1:0] wptr_q, rptr_q;
  logic [Q_AW:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == (Q_AW+1)'(Q_DEPTH);
  assign empty_o = cnt_q == '0;
  assign data_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    cnt_d = cnt_q;
    unique case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + (Q_AW+1)'(1);
      2'b01:   cnt_d = cnt_q - (Q_AW+1)'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wptr_q <= wptr_q + Q_AW'(1);
      if (do_pop)  rptr_q <= rptr_q + Q_AW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) slot_q[wptr_q] <= data_i;
  end

  `CTBC_ASSERT_NEVER(a_no_overflow, clk_i, rst_ni, push_i && full_o, "push into full queue")
  `CTBC_ASSERT_CLK(a_cnt_bound, clk_i, rst_ni, cnt_q <= (Q_AW+1)'(Q_DEPTH), "queue count too high")

endmodule

`default_nettype wire

// ===== design/ctbc_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "color_threshold_blob_centroid_core_macros.svh"

module ctbc_back (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        q_empty_i,
  input  ctbc_pkg::ctbc_entry_t      q_data_i,
  output logic                       q_pop_o,
  output logic                       empty_o,
  input  wire                        pop_i,
  output logic [ctbc_pkg::PIX_W-1:0] out_pixel_o,
  output logic                       frame_done_o,
  output logic                       blob_found_o,
  output logic [ctbc_pkg::CX_W-1:0]  centre_x_o,
  output logic [ctbc_pkg::CY_W-1:0]  centre_y_o
);
  import ctbc_pkg::*;

  localparam int unsigned STEP_W = $clog2(SUM_W);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [CNT_W-1:0]  div_q, div_d;
  logic [CNT_W-1:0]  rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic [SUM_W-1:0]  quo_x_q, quo_x_d, quo_y_q, quo_y_d;
  logic [PIX_W-1:0]  pix_q, pix_d;

  logic              out_valid_q, out_valid_d;
  logic [PIX_W-1:0]  out_pixel_q, out_pixel_d;
  logic              out_done_q, out_done_d;
  logic              out_found_q, out_found_d;
  logic [CX_W-1:0]   out_cx_q, out_cx_d;
  logic [CY_W-1:0]   out_cy_q, out_cy_d;

  logic              out_free, out_take;
  logic [CNT_W:0]    sh_x, sh_y, dif_x, dif_y;

  assign out_take = pop_i && out_valid_q;
  assign out_free = !out_valid_q || pop_i;

  always_comb begin
    // one restoring step for x and y side by side
    sh_x  = {rem_x_q, quo_x_q[SUM_W-1]};
    sh_y  = {rem_y_q, quo_y_q[SUM_W-1]};
    dif_x = sh_x - {1'b0, div_q};
    dif_y = sh_y - {1'b0, div_q};

    state_d     = state_q;
    step_d      = step_q;
    div_d       = div_q;
    rem_x_d     = rem_x_q;
    rem_y_d     = rem_y_q;
    quo_x_d     = quo_x_q;
    quo_y_d     = quo_y_q;
    pix_d       = pix_q;
    q_pop_o     = 1'b0;
    out_valid_d = out_take ? 1'b0 : out_valid_q;
    out_pixel_d = out_pixel_q;
    out_done_d  = out_done_q;
    out_found_d = out_found_q;
    out_cx_d    = out_cx_q;
    out_cy_d    = out_cy_q;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          priority if (q_data_i.found) begin
            q_pop_o = 1'b1;
            div_d   = q_data_i.cnt;
            quo_x_d = q_data_i.sum_x;
            quo_y_d = q_data_i.sum_y;
            rem_x_d = '0;
            rem_y_d = '0;
            pix_d   = q_data_i.pixel;
            step_d  = '0;
            state_d = ST_DIV;
          end else begin
            if (out_free) begin
              q_pop_o     = 1'b1;
              out_valid_d = 1'b1;
              out_pixel_d = q_data_i.pixel;
              out_done_d  = q_data_i.last;
              out_found_d = 1'b0;
              out_cx_d    = q_data_i.last ? CX_W'(COLS) : '0;
              out_cy_d    = q_data_i.last ? CY_W'(ROWS) : '0;
            end
          end
        end
      end
      ST_DIV: begin
        if (!dif_x[CNT_W]) begin
          rem_x_d = dif_x[CNT_W-1:0];
        end else begin
          rem_x_d = sh_x[CNT_W-1:0];
        end
        if (!dif_y[CNT_W]) begin
          rem_y_d = dif_y[CNT_W-1:0];
        end else begin
          rem_y_d = sh_y[CNT_W-1:0];
        end
        quo_x_d = {quo_x_q[SUM_W-2:0], !dif_x[CNT_W]};
        quo_y_d = {quo_y_q[SUM_W-2:0], !dif_y[CNT_W]};
        step_d  = step_q + STEP_W'(1);
        if (step_q == STEP_W'(SUM_W - 1)) state_d = ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_pixel_d = pix_q;
          out_done_d  = 1'b1;
          out_found_d = 1'b1;
          out_cx_d    = quo_x_q[CX_W-1:0];
          out_cy_d    = quo_y_q[CY_W-1:0];
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q       <= div_d;
    rem_x_q     <= rem_x_d;
    rem_y_q     <= rem_y_d;
    quo_x_q     <= quo_x_d;
    quo_y_q     <= quo_y_d;
    pix_q       <= pix_d;
    out_pixel_q <= out_pixel_d;
    out_done_q  <= out_done_d;
    out_found_q <= out_found_d;
    out_cx_q    <= out_cx_d;
    out_cy_q    <= out_cy_d;
  end

  assign empty_o      = !out_valid_q;
  assign out_pixel_o  = out_pixel_q;
  assign frame_done_o = out_done_q;
  assign blob_found_o = out_found_q;
  assign centre_x_o   = out_cx_q;
  assign centre_y_o   = out_cy_q;

  `CTBC_ASSERT_CLK(a_div_nonzero, clk_i, rst_ni,
                   (state_q == ST_DIV) |-> (div_q != '0), "divide by zero")
  `CTBC_ASSERT_CLK(a_mid_frame_clear, clk_i, rst_ni,
                   (out_valid_q && !out_done_q) |->
                   (!out_found_q && out_cx_q == '0 && out_cy_q == '0),
                   "centre set mid frame")

endmodule

`default_nettype wire

// ===== tb/sv/tb_color_threshold_blob_centroid_core.sv =====
`timescale 1ns / 1ps

module tb_color_threshold_blob_centroid_core;
  import ctbc_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;  // unmapped index, writes dropped
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned HOLD_AFTER    = 300;
  localparam int unsigned N_VECTORS     = 14;
  localparam int unsigned N_PHASES      = 10;
  localparam int unsigned PAUSE_PHASE   = 5;
  localparam int unsigned PAUSE_AT      = 60;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             done;
    logic             found;
    logic [CX_W-1:0]  cx;
    logic [CY_W-1:0]  cy;
  } blob_res_t;

  typedef struct packed {
    logic      pinned;
    blob_res_t res;
  } pinned_t;

  typedef struct packed {
    logic [PIX_W-1:0] v;
    logic             pinned;
    logic [PIX_W-1:0] pixel;
  } vec_row_t;

  typedef enum logic [1:0] {FILL_NOISE, FILL_BLOB, FILL_SPARSE} fill_e;

  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    logic [CNT_W-1:0] min_cnt;
    fill_e            fill;
    int unsigned      n_items;  // zero: run on to the end of the frame
  } phase_t;

  // Default window after reset is 200..240.
  localparam vec_row_t VECTORS [N_VECTORS] = '{
    '{8'd0,   1'b1, 8'd0},
    '{8'd255, 1'b1, 8'd255},
    '{8'd199, 1'b1, 8'd199},
    '{8'd200, 1'b1, 8'd0},
    '{8'd240, 1'b1, 8'd0},
    '{8'd241, 1'b1, 8'd241},
    '{8'hAA,  1'b1, 8'hAA},
    '{8'h55,  1'b1, 8'h55},
    '{8'd220, 1'b1, 8'd0},
    '{8'h80,  1'b1, 8'h80},
    '{8'd201, 1'b0, 8'd0},
    '{8'd239, 1'b0, 8'd0},
    '{8'd1,   1'b0, 8'd0},
    '{8'd254, 1'b0, 8'd0}
  };

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;
  logic             push;
  logic             full;
  logic [PIX_W-1:0] v_sample_i;
  logic             empty;
  logic             pop;
  logic [PIX_W-1:0] out_pixel_o;
  logic             frame_done_o;
  logic             blob_found_o;
  logic [CX_W-1:0]  centre_x_o;
  logic [CY_W-1:0]  centre_y_o;

  color_threshold_blob_centroid_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .push         (push),
    .full         (full),
    .v_sample_i   (v_sample_i),
    .empty        (empty),
    .pop          (pop),
    .out_pixel_o  (out_pixel_o),
    .frame_done_o (frame_done_o),
    .blob_found_o (blob_found_o),
    .centre_x_o   (centre_x_o),
    .centre_y_o   (centre_y_o)
  );

  // Centroid predictor: window, threshold and per-frame accumulators.
  logic [PIX_W-1:0] win_lo;
  logic [PIX_W-1:0] win_hi;
  logic [CNT_W-1:0] min_hits;
  logic [COL_W-1:0] cur_col;
  logic [ROW_W-1:0] cur_row;
  logic [SUM_W-1:0] acc_x;
  logic [SUM_W-1:0] acc_y;
  logic [CNT_W-1:0] hit_cnt;

  blob_res_t   grade_q[$];
  pinned_t     pinned_q[$];
  int unsigned n_errors;
  int unsigned n_results;

  // Sender side: raster position of the next item, burst state, blob box.
  int unsigned gen_col;
  int unsigned gen_row;
  int unsigned burst_left;
  int unsigned box_x0, box_x1, box_y0, box_y1;
  phase_t      plan [N_PHASES];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #25_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic blob_res_t grade_sample(logic [PIX_W-1:0] v);
    blob_res_t r;
    logic      hit;
    logic      last_col;
    logic      last_px;
    r        = '0;
    hit      = (v >= win_lo) && (v <= win_hi);
    last_col = cur_col >= COL_W'(COLS - 1);
    last_px  = last_col && (cur_row >= ROW_W'(ROWS - 1));
    if (hit) begin
      acc_x   = acc_x + SUM_W'(2 * cur_col);
      acc_y   = acc_y + SUM_W'(2 * cur_row);
      hit_cnt = hit_cnt + 1'b1;
    end
    r.pixel = hit ? '0 : v;
    r.done  = last_px;
    if (last_px) begin
      if (hit_cnt > min_hits && hit_cnt != 0) begin
        r.found = 1'b1;
        r.cx    = CX_W'(acc_x / hit_cnt);
        r.cy    = CY_W'(acc_y / hit_cnt);
      end else begin
        r.cx = CX_W'(COLS);
        r.cy = CY_W'(ROWS);
      end
      cur_col = '0;
      cur_row = '0;
      acc_x   = '0;
      acc_y   = '0;
      hit_cnt = '0;
    end else if (last_col) begin
      cur_col = '0;
      cur_row = cur_row + 1'b1;
    end else begin
      cur_col = cur_col + 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : scoreboard
    blob_res_t want;
    blob_res_t got;
    pinned_t   pin;
    if (!rst_ni) begin
      win_lo   = V_MIN_RST;
      win_hi   = V_MAX_RST;
      min_hits = MIN_COUNT_RST;
      cur_col  = '0;
      cur_row  = '0;
      acc_x    = '0;
      acc_y    = '0;
      hit_cnt  = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_V_MIN:     win_lo   = cfg_wdata_i[PIX_W-1:0];
          REG_V_MAX:     win_hi   = cfg_wdata_i[PIX_W-1:0];
          REG_MIN_COUNT: min_hits = cfg_wdata_i[CNT_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) begin
        want = grade_sample(v_sample_i);
        if (pinned_q.size() != 0) begin
          pin = pinned_q.pop_front();
          if (pin.pinned) want = pin.res;
        end
        grade_q.push_back(want);
      end
      if (pop && !empty) begin
        got.pixel = out_pixel_o;
        got.done  = frame_done_o;
        got.found = blob_found_o;
        got.cx    = centre_x_o;
        got.cy    = centre_y_o;
        n_results++;
        if (grade_q.size() == 0) begin
          n_errors++;
          if (n_errors <= MAX_REPORTS)
            $display("%0t: result item with nothing outstanding: pixel %0d done %0b",
                     $time, got.pixel, got.done);
        end else begin
          want = grade_q.pop_front();
          if (got.pixel !== want.pixel || got.done !== want.done ||
              got.found !== want.found || got.cx !== want.cx || got.cy !== want.cy) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
              $display({"%0t: mismatch (exp/got) pixel %0d/%0d done %0b/%0b ",
                        "found %0b/%0b cx %0d/%0d cy %0d/%0d"}, $time,
                       want.pixel, got.pixel, want.done, got.done, want.found,
                       got.found, want.cx, got.cx, want.cy, got.cy);
          end
        end
      end
    end
  end

  // Result side: runs of pops broken by short stalls, one long hold-off.
  initial begin : drain_side
    int unsigned run_len;
    int unsigned stall_len;
    bit          held;
    pop  <= 1'b0;
    held = 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      run_len   = ($urandom_range(7, 0) == 0) ? 200 : $urandom_range(40, 4);
      stall_len = $urandom_range(5, 1);
      repeat (run_len) begin
        pop <= 1'b1;
        @(posedge clk_i);
      end
      if (!held && n_results >= HOLD_AFTER) begin
        held      = 1'b1;
        stall_len = HOLD_CYCLES;
      end
      repeat (stall_len) begin
        pop <= 1'b0;
        @(posedge clk_i);
      end
    end
  end

  function automatic logic [PIX_W-1:0] window_value(phase_t ph);
    if (ph.lo <= ph.hi) return PIX_W'($urandom_range(ph.hi, ph.lo));
    return PIX_W'($urandom);
  endfunction

  function automatic logic [PIX_W-1:0] outside_value(phase_t ph);
    logic [PIX_W-1:0] v;
    v = PIX_W'($urandom);
    for (int i = 0; i < 8 && v >= ph.lo && v <= ph.hi; i++) v = PIX_W'($urandom);
    return v;
  endfunction

  function automatic logic [PIX_W-1:0] scene_sample(phase_t ph);
    bit in_box;
    bit last_px;
    in_box  = gen_col >= box_x0 && gen_col <= box_x1 &&
              gen_row >= box_y0 && gen_row <= box_y1;
    last_px = gen_col == COLS - 1 && gen_row == ROWS - 1;
    case (ph.fill)
      FILL_BLOB: begin
        // force the corner sample into the window so it counts for its own frame
        if (last_px) return window_value(ph);
        if ($urandom_range(63, 0) == 0) return PIX_W'($urandom);
        return in_box ? window_value(ph) : outside_value(ph);
      end
      FILL_SPARSE:
        return ($urandom_range(1023, 0) == 0) ? window_value(ph) : outside_value(ph);
      default:
        return PIX_W'($urandom);
    endcase
  endfunction

  task automatic offer(input logic [PIX_W-1:0] v);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(5, 0) == 0) ? 0 : $urandom_range(6, 1);
      if (gap != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(64, 8);
    end
    push       <= 1'b1;
    v_sample_i <= v;
    do @(posedge clk_i); while (full);
    burst_left--;
    if (gen_col == COLS - 1) begin
      gen_col = 0;
      gen_row = (gen_row == ROWS - 1) ? 0 : gen_row + 1;
    end else begin
      gen_col++;
    end
  endtask

  // Drop push and wait for every outstanding item; sample on the falling edge.
  task automatic drain();
    push <= 1'b0;
    @(negedge clk_i);
    while (grade_q.size() != 0) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_regs(phase_t ph);
    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_V_MIN;
    cfg_wdata_i <= CFG_W'({$urandom, ph.lo});
    @(posedge clk_i);
    cfg_idx_i   <= REG_V_MAX;
    cfg_wdata_i <= CFG_W'({$urandom, ph.hi});
    @(posedge clk_i);
    cfg_idx_i   <= REG_MIN_COUNT;
    cfg_wdata_i <= ph.min_cnt;
    @(posedge clk_i);
    cfg_idx_i   <= REG_SPARE;
    cfg_wdata_i <= CFG_W'($urandom);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin : feed_side
    pinned_t     pin;
    int unsigned sent;
    rst_ni      <= 1'b0;
    push        <= 1'b0;
    v_sample_i  <= '0;
    cfg_we_i    <= 1'b0;
    cfg_idx_i   <= REG_V_MIN;
    cfg_wdata_i <= '0;
    n_errors   = 0;
    n_results  = 0;
    gen_col    = 0;
    gen_row    = 0;
    burst_left = 0;

    plan[0] = '{8'd200, 8'd240, 15'd5,     FILL_NOISE,  120};
    plan[1] = '{8'd0,   8'd255, 15'd0,     FILL_NOISE,  60};
    plan[2] = '{8'd0,   8'd255, 15'd19200, FILL_NOISE,  60};
    plan[3] = '{8'd100, 8'd150, 15'd0,     FILL_BLOB,   250};
    plan[4] = '{8'd240, 8'd200, 15'd0,     FILL_NOISE,  60};
    plan[5] = '{8'd255, 8'd255, 15'd32767, FILL_NOISE,  120};
    plan[6] = '{8'd90,  8'd170, 15'd40,    FILL_BLOB,   60};
    plan[7] = '{8'd0,   8'd0,   15'd3,     FILL_SPARSE, 40};
    plan[8] = '{PIX_W'($urandom), PIX_W'($urandom), CNT_W'($urandom_range(400, 0)),
                FILL_BLOB, 40};
    plan[9] = '{PIX_W'($urandom), PIX_W'($urandom), CNT_W'($urandom_range(15, 0)),
                FILL_SPARSE, 26};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < N_VECTORS; i++) begin
      pin.pinned    = VECTORS[i].pinned;
      pin.res       = '0;
      pin.res.pixel = VECTORS[i].pixel;
      pinned_q.push_back(pin);
      offer(VECTORS[i].v);
    end

    for (int p = 0; p < N_PHASES; p++) begin
      write_regs(plan[p]);
      box_x0 = $urandom_range(COLS - 1, 0);
      box_x1 = (box_x0 + $urandom_range(79, 0) > COLS - 1) ? COLS - 1
             : box_x0 + $urandom_range(79, 0);
      box_y0 = $urandom_range(ROWS - 1, 0);
      box_y1 = (box_y0 + $urandom_range(59, 0) > ROWS - 1) ? ROWS - 1
             : box_y0 + $urandom_range(59, 0);
      sent = 0;
      do begin
        // hold the input until the block has handed back everything
        if (p == PAUSE_PHASE && sent == PAUSE_AT) drain();
        offer(scene_sample(plan[p]));
        sent++;
      end while (plan[p].n_items != 0 ? sent < plan[p].n_items
                                      : !(gen_col == 0 && gen_row == 0));
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (n_errors == 0 && grade_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
